// ===== design/kes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kes_pkg
// Shared types and defaults for the key exchange sorter.
// ----------------------------------------------------------------------------
package kes_pkg;

    localparam int MAX_KEYS_DEF = 64;
    localparam int KEY_BITS_DEF = 19;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD_I,
        ST_GET_I,
        ST_SCAN,
        ST_PUT_I,
        ST_ERD,
        ST_EWAIT
    } kes_state_t;

    // Key RAM port strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } kes_mem_ctl_t;

endpackage

// ===== design/kes_key_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kes_key_ram
// Key store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kes_key_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 19,
    parameter int AW    = 6
) (
    input  logic                  clk,
    input  kes_pkg::kes_mem_ctl_t ctl,
    input  logic [AW-1:0]         wr_addr,
    input  logic [WIDTH-1:0]      wr_data,
    input  logic [AW-1:0]         rd_addr,
    output logic [WIDTH-1:0]      rd_data
);
    import kes_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/kes_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kes_ctrl
// Sequencer with the shared key comparator: load, exchange sort, emit.
// ----------------------------------------------------------------------------
module kes_ctrl #(
    parameter int MAX_KEYS = 64,
    parameter int KEY_BITS = 19,
    parameter int AW       = 6,
    parameter int CNT_W    = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [KEY_BITS-1:0]   key,
    input  logic                  last,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [KEY_BITS-1:0]   sorted_key,
    output logic                  end_of_list,
    output logic                  overflow,
    output kes_pkg::kes_mem_ctl_t mem_ctl,
    output logic [AW-1:0]         wr_addr,
    output logic [KEY_BITS-1:0]   wr_data,
    output logic [AW-1:0]         rd_addr,
    input  logic [KEY_BITS-1:0]   rd_data
);
    import kes_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_KEYS);
    localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO     = CNT_W'(2);

    kes_state_t            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  drop_reg, drop_next;
    logic [CNT_W-1:0]      i_reg, i_next;
    logic [CNT_W-1:0]      j_reg, j_next;
    logic [AW-1:0]         jc_reg, jc_next;
    logic [KEY_BITS-1:0]   cur_reg, cur_next;
    logic                  out_valid_reg, out_valid_next;
    logic [KEY_BITS-1:0]   out_key_reg, out_key_next;
    logic                  out_end_reg, out_end_next;
    logic                  out_ovf_reg, out_ovf_next;

    logic                  in_fire;
    logic                  has_room;
    logic [CNT_W-1:0]      count_after;
    logic                  swap;
    logic                  out_load;
    logic                  more_i;
    logic                  last_k;

    assign in_fire     = in_valid && (state_reg == ST_LOAD);
    assign has_room    = count_reg < MAX_CNT;
    assign count_after = has_room ? count_reg + ONE : count_reg;
    assign swap        = rd_data < cur_reg;
    assign out_load    = !out_valid_reg || out_ready;
    assign more_i      = (i_reg + TWO) < count_reg;
    assign last_k      = i_reg == (count_reg - ONE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && last)
                begin
                    state_next = (count_after >= TWO) ? ST_RD_I : ST_ERD;
                end
            end
            ST_RD_I:  state_next = ST_GET_I;
            ST_GET_I: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (j_reg >= count_reg)
                begin
                    state_next = ST_PUT_I;
                end
            end
            ST_PUT_I: state_next = more_i ? ST_GET_I : ST_ERD;
            ST_ERD:   state_next = ST_EWAIT;
            ST_EWAIT:
            begin
                if (out_load)
                begin
                    state_next = last_k ? ST_LOAD : ST_ERD;
                end
            end
            default:  state_next = ST_LOAD;
        endcase
    end

    // Outputs and datapath next values
    always_comb
    begin
        in_ready       = 1'b0;
        mem_ctl        = '0;
        wr_addr        = count_reg[AW-1:0];
        wr_data        = key;
        rd_addr        = i_reg[AW-1:0];
        count_next     = count_reg;
        drop_next      = drop_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        jc_next        = jc_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_key_next   = out_key_reg;
        out_end_next   = out_end_reg;
        out_ovf_next   = out_ovf_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    // Store while room is left, else drop and flag
                    mem_ctl.wr_en = has_room;
                    count_next    = count_after;
                    drop_next     = drop_reg || !has_room;
                    i_next        = '0;
                end
            end
            ST_RD_I:
            begin
                mem_ctl.rd_en = 1'b1;
                j_next        = i_reg + ONE;
            end
            ST_GET_I:
            begin
                cur_next      = rd_data;
                mem_ctl.rd_en = 1'b1;
                rd_addr       = j_reg[AW-1:0];
                jc_next       = j_reg[AW-1:0];
                j_next        = j_reg + ONE;
            end
            ST_SCAN:
            begin
                // Compare key j against the running key of position i
                if (swap)
                begin
                    mem_ctl.wr_en = 1'b1;
                    wr_addr       = jc_reg;
                    wr_data       = cur_reg;
                    cur_next      = rd_data;
                end
                if (j_reg < count_reg)
                begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = j_reg[AW-1:0];
                    jc_next       = j_reg[AW-1:0];
                    j_next        = j_reg + ONE;
                end
            end
            ST_PUT_I:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = i_reg[AW-1:0];
                wr_data       = cur_reg;
                if (more_i)
                begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = AW'(i_reg + ONE);
                    i_next        = i_reg + ONE;
                    j_next        = i_reg + TWO;
                end
                else
                begin
                    i_next = '0;
                end
            end
            ST_ERD:
            begin
                mem_ctl.rd_en = 1'b1;
            end
            ST_EWAIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_key_next   = rd_data;
                    out_end_next   = last_k;
                    out_ovf_next   = drop_reg;
                    i_next         = i_reg + ONE;
                    if (last_k)
                    begin
                        count_next = '0;
                        drop_next  = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        jc_reg      <= jc_next;
        cur_reg     <= cur_next;
        out_key_reg <= out_key_next;
        out_end_reg <= out_end_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign out_valid   = out_valid_reg;
    assign sorted_key  = out_key_reg;
    assign end_of_list = out_end_reg;
    assign overflow    = out_ovf_reg;

endmodule

// ===== design/key_exchange_sorter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_exchange_sorter_top
// Collects a list of keys, exchange-sorts it in a RAM, streams it out ascending.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload                              Per list
//  -------  -------------------  -----------------------------------  --------------
//  in       in_valid / in_ready  key, last                            one per key
//  out      out_valid/out_ready  sorted_key, end_of_list, overflow    one per stored key
//
//  While loading, in_ready stays high. On the transfer carrying last the block
//  drops in_ready and sorts (a list of one key goes straight to emit), one key
//  compare per cycle on the single comparator against the one-read-port key RAM.
//  Emitting then reads each key from the RAM and loads it into the output register.
//  A stalled output holds its register and the sequencer; in_ready returns when
//  the last key of the list sits in the output register. Reset empties the list.
//
module key_exchange_sorter_top #(
    parameter int MAX_KEYS = kes_pkg::MAX_KEYS_DEF,
    parameter int KEY_BITS = kes_pkg::KEY_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [KEY_BITS-1:0] key,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [KEY_BITS-1:0] sorted_key,
    output logic                end_of_list,
    output logic                overflow
);
    import kes_pkg::*;

    // RAM address width and a count wide enough to hold MAX_KEYS itself
    localparam int AW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W = $clog2(MAX_KEYS + 1);

    kes_mem_ctl_t        mem_ctl;
    logic [AW-1:0]       wr_addr;
    logic [KEY_BITS-1:0] wr_data;
    logic [AW-1:0]       rd_addr;
    logic [KEY_BITS-1:0] rd_data;

    // Sequencer, comparator and output register
    kes_ctrl #(
        .MAX_KEYS (MAX_KEYS),
        .KEY_BITS (KEY_BITS),
        .AW       (AW),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .key         (key),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sorted_key  (sorted_key),
        .end_of_list (end_of_list),
        .overflow    (overflow),
        .mem_ctl     (mem_ctl),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    // Key store; never read past the current fill, so no clearing is needed
    kes_key_ram #(
        .DEPTH (MAX_KEYS),
        .WIDTH (KEY_BITS),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // A list still streaming out keeps the input closed
    a_no_load_mid_list: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !end_of_list) |-> !in_ready)
        else $error("input open while sorted keys are still pending");

    // Closing transfer starts the sort or emit phase
    a_close_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last) |=> !in_ready)
        else $error("input still open after list close");

    // Keys without last keep the block loading
    a_keep_loading: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !last) |=> in_ready)
        else $error("input closed in the middle of a list load");

endmodule

// ===== tb/kes_sort_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kes_sort_checker
// Watches both channels, sorts each closed list itself and checks the results.
// ----------------------------------------------------------------------------
module kes_sort_checker #(
    parameter int MAX_KEYS = kes_pkg::MAX_KEYS_DEF,
    parameter int KEY_BITS = kes_pkg::KEY_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [KEY_BITS-1:0] key,
    input  logic                last,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [KEY_BITS-1:0] sorted_key,
    input  logic                end_of_list,
    input  logic                overflow,
    output int                  mismatches,
    output int                  keys_owed
);

    typedef struct packed {
        logic [KEY_BITS-1:0] key_val;
        logic                eol;
        logic                ovf;
    } sorted_entry_t;

    logic [KEY_BITS-1:0] list_keys [MAX_KEYS];
    int                  list_len;
    logic                list_dropped;
    sorted_entry_t       sorted_due [$];
    int                  errors;

    task automatic note_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("[%0t] %s", $time, msg);
    endtask

    // Exchange-sort the open list, queue its results, start a new list.
    task automatic close_list();
        logic [KEY_BITS-1:0] swap_key;
        sorted_entry_t       entry;
        for (int i = 0; i + 1 < list_len; i++)
            for (int j = i + 1; j < list_len; j++)
                if (list_keys[j] < list_keys[i])
                begin
                    swap_key     = list_keys[j];
                    list_keys[j] = list_keys[i];
                    list_keys[i] = swap_key;
                end
        for (int n = 0; n < list_len; n++)
        begin
            entry.key_val = list_keys[n];
            entry.eol     = (n == list_len - 1);
            entry.ovf     = list_dropped;
            sorted_due.push_back(entry);
        end
        list_len     = 0;
        list_dropped = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        sorted_entry_t seen;
        sorted_entry_t want;
        if (!rst_n)
        begin
            list_len     = 0;
            list_dropped = 1'b0;
            errors       = 0;
            sorted_due.delete();
            mismatches <= 0;
            keys_owed  <= 0;
        end
        else
        begin
            // Check the output transfer against the oldest queued result.
            if (out_valid && out_ready)
            begin
                seen = {sorted_key, end_of_list, overflow};
                if (sorted_due.size() == 0)
                    note_error($sformatf("unexpected result: key=%0d eol=%0b ovf=%0b",
                                         seen.key_val, seen.eol, seen.ovf));
                else
                begin
                    want = sorted_due.pop_front();
                    if (seen.key_val !== want.key_val || seen.eol !== want.eol ||
                        seen.ovf !== want.ovf)
                        note_error($sformatf(
                            "expected key=%0d eol=%0b ovf=%0b, got key=%0d eol=%0b ovf=%0b",
                            want.key_val, want.eol, want.ovf,
                            seen.key_val, seen.eol, seen.ovf));
                end
            end
            // Store the input key, or drop it when the list is full.
            if (in_valid && in_ready)
            begin
                if (list_len < MAX_KEYS)
                begin
                    list_keys[list_len] = key;
                    list_len++;
                end
                else
                    list_dropped = 1'b1;
                if (last)
                    close_list();
            end
            mismatches <= errors;
            keys_owed  <= sorted_due.size();
        end
    end

endmodule

// ===== tb/tb_key_exchange_sorter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_exchange_sorter_top
// Drives key lists into the sorter and gives the verdict from the checker.
// ----------------------------------------------------------------------------
//
// A short directed part covers single-key lists, the key extremes, equal keys,
// alternating bit patterns and already sorted or reversed lists. The random
// part sends lists of random length and content: mostly short, one exactly
// full list and one that overflows (its closing key dropped too). Both sides
// idle in random bursts; early in the random part the receiver holds off for
// a long stretch so the block fills up and stalls its input. The tail of the
// run has no idling. The checker predicts every result and counts failures.
//
module tb_key_exchange_sorter_top;
    import kes_pkg::*;

    localparam int                  MAX_KEYS        = MAX_KEYS_DEF;
    localparam int                  KEY_BITS        = KEY_BITS_DEF;
    localparam logic [KEY_BITS-1:0] KEY_TOP         = '1;
    localparam int                  RANDOM_ITEMS    = 160;
    localparam int                  CALM_AFTER      = 140;
    localparam int                  HOLD_OFF_CYCLES = 3000;
    localparam int                  STALL_LIMIT     = 20000;
    localparam int                  DRAIN_CYCLES    = 200;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [KEY_BITS-1:0] key;
    logic                last;
    logic                out_valid;
    logic                out_ready;
    logic [KEY_BITS-1:0] sorted_key;
    logic                end_of_list;
    logic                overflow;

    // calm: no idling on either side; hold_go: receiver starts its long hold-off
    logic calm;
    logic hold_go;
    int   mismatches;
    int   keys_owed;
    int   items_sent;
    int   stall_count;

    key_exchange_sorter_top #(
        .MAX_KEYS (MAX_KEYS),
        .KEY_BITS (KEY_BITS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .key         (key),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sorted_key  (sorted_key),
        .end_of_list (end_of_list),
        .overflow    (overflow)
    );

    kes_sort_checker #(
        .MAX_KEYS (MAX_KEYS),
        .KEY_BITS (KEY_BITS)
    ) sort_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .key         (key),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sorted_key  (sorted_key),
        .end_of_list (end_of_list),
        .overflow    (overflow),
        .mismatches  (mismatches),
        .keys_owed   (keys_owed)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Offer one key and hold it until the transfer. Call at a rising edge;
    // returns at the edge of the transfer with in_valid still high, so the
    // next call can present its key without dropping valid in between.
    task automatic send_key(input logic [KEY_BITS-1:0] k, input logic closes);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        key      <= k;
        last     <= closes;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Send one list of len keys; the content style is picked per list.
    task automatic send_random_list(input int len);
        int                  style;
        logic [KEY_BITS-1:0] k;
        style = $urandom_range(0, 3);
        for (int n = 0; n < len; n++)
        begin
            case (style)
                0, 1:    k = KEY_BITS'($urandom);              // full key range
                2:       k = KEY_BITS'($urandom_range(0, 7));  // crowd of duplicates
                default:
                begin
                    // extremes mixed with random keys
                    case ($urandom_range(0, 2))
                        0:       k = '0;
                        1:       k = KEY_TOP;
                        default: k = KEY_BITS'($urandom);
                    endcase
                end
            endcase
            send_key(k, n == len - 1);
        end
    endtask

    // Stimulus: reset, directed lists, random lists, drain, verdict.
    initial
    begin : stimulus
        int list_no;
        int len;
        int pick;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        key        <= '0;
        last       <= 1'b0;
        calm       = 1'b0;
        hold_go    <= 1'b0;
        items_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-key lists at both extremes
        send_key('0, 1'b1);
        send_key(KEY_TOP, 1'b1);
        // extremes, alternating bits and equal keys in one list
        send_key(KEY_TOP, 1'b0);
        send_key('0, 1'b0);
        send_key(19'h40000, 1'b0);
        send_key(19'h2AAAA, 1'b0);
        send_key(19'h55555, 1'b0);
        send_key(19'd5, 1'b0);
        send_key(19'd5, 1'b0);
        send_key(19'd1, 1'b1);
        // already ascending, then reversed
        send_key(19'd1, 1'b0);
        send_key(19'd2, 1'b0);
        send_key(19'd3, 1'b1);
        send_key(19'd3, 1'b0);
        send_key(19'd2, 1'b0);
        send_key(19'd1, 1'b1);
        // two equal keys
        send_key(19'd7, 1'b0);
        send_key(19'd7, 1'b1);

        // Random part: start the receiver's long hold-off right away so the
        // next lists pile up behind a stalled output. Always finish with at
        // least one list sent without idling.
        items_sent = 0;
        hold_go    <= 1'b1;
        list_no    = 0;
        while (list_no < 5 || items_sent < RANDOM_ITEMS || !calm)
        begin
            if (list_no >= 5 && items_sent >= CALM_AFTER)
                calm = 1'b1;
            if (list_no == 1)
                len = MAX_KEYS;             // exactly full, nothing dropped
            else if (list_no == 4)
                len = MAX_KEYS + 2;         // overflow, closing key dropped
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    len = $urandom_range(1, 8);
                else
                    len = $urandom_range(9, 20);
            end
            send_random_list(len);
            list_no++;
        end
        in_valid <= 1'b0;

        // Let the count of owed results settle, drain them, then wait out
        // the block's own tail.
        @(posedge clk);
        while (keys_owed != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && keys_owed == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random ready bursts, one long hold-off, steady ready when calm.
    initial
    begin : receiver
        bit held;
        held      = 1'b0;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_go && !held)
            begin
                held      = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // Watchdog: end the run when nothing transfers for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_count <= 0;
        else if (stall_count >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            stall_count <= stall_count + 1;
    end

endmodule

// ===== files.f =====
design/kes_pkg.sv
design/kes_key_ram.sv
design/kes_ctrl.sv
design/key_exchange_sorter_top.sv
tb/kes_sort_checker.sv
tb/tb_key_exchange_sorter_top.sv
